[hdl/glyph_shape_record_decoder_top_defines.svh]
// assertion helpers shared by the decoder rtl
`ifndef GLYPH_SHAPE_RECORD_DECODER_TOP_DEFINES_SVH
`define GLYPH_SHAPE_RECORD_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GSRD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define GSRD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/gsrd_pkg.sv]
package gsrd_pkg;

   // pen coordinate width, wraps modulo 2**COORD_WIDTH
   localparam int COORD_WIDTH = 32;

   // parse phases
   localparam logic [3:0] PH_WAIT      = 4'd0;
   localparam logic [3:0] PH_TYPE      = 4'd1;
   localparam logic [3:0] PH_NEWSTYLE  = 4'd2;
   localparam logic [3:0] PH_FLAGS     = 4'd3;
   localparam logic [3:0] PH_MBITS     = 4'd4;
   localparam logic [3:0] PH_MX        = 4'd5;
   localparam logic [3:0] PH_MY        = 4'd6;
   localparam logic [3:0] PH_F0        = 4'd7;
   localparam logic [3:0] PH_F1        = 4'd8;
   localparam logic [3:0] PH_LS        = 4'd9;
   localparam logic [3:0] PH_EDGEHEAD  = 4'd10;
   localparam logic [3:0] PH_LINEGEN   = 4'd11;
   localparam logic [3:0] PH_LINEVERT  = 4'd12;
   localparam logic [3:0] PH_DELTA     = 4'd13;

   // drawing commands
   localparam logic [2:0] CMD_MOVE       = 3'd0;
   localparam logic [2:0] CMD_LINE       = 3'd1;
   localparam logic [2:0] CMD_CURVE      = 3'd2;
   localparam logic [2:0] CMD_LEFT_FILL  = 3'd3;
   localparam logic [2:0] CMD_RIGHT_FILL = 3'd4;
   localparam logic [2:0] CMD_LINE_OFF   = 3'd5;
   localparam logic [2:0] CMD_END        = 3'd6;

   // state-change flag bits
   localparam int FLAG_MOVE  = 0;
   localparam int FLAG_FILL0 = 1;
   localparam int FLAG_FILL1 = 2;
   localparam int FLAG_LINE  = 3;

   // edge kinds held in the upper flag bits
   localparam logic [1:0] KIND_CURVE = 2'd0;
   localparam logic [1:0] KIND_LINE  = 2'd1;
   localparam logic [1:0] KIND_VERT  = 2'd2;
   localparam logic [1:0] KIND_HORZ  = 2'd3;

   localparam logic [4:0] MOVE_BITS = 5'd5;
   localparam logic [4:0] FLAG_BITS = 5'd4;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      logic [3:0] phase;
      logic [4:0] width;
   } gsrd_step_type;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] ctrl_x;
      logic signed [31:0] ctrl_y;
   } gsrd_result_type;

   // next field after a part of a state-change record
   function automatic gsrd_step_type sc_next(logic [3:0] from, logic [3:0] flags,
                                             logic [3:0] fiw, logic [3:0] liw);
      gsrd_step_type s;
      priority if (from < PH_MBITS && flags[FLAG_MOVE]) begin
         s = '{phase: PH_MBITS, width: MOVE_BITS};
      end else if (from < PH_F0 && flags[FLAG_FILL0]) begin
         s = '{phase: PH_F0, width: {1'b0, fiw}};
      end else if (from < PH_F1 && flags[FLAG_FILL1]) begin
         s = '{phase: PH_F1, width: {1'b0, fiw}};
      end else if (from < PH_LS && flags[FLAG_LINE]) begin
         s = '{phase: PH_LS, width: {1'b0, liw}};
      end else begin
         s = '{phase: PH_TYPE, width: 5'd1};
      end
      return s;
   endfunction

   // sign-extend a field of w bits; bits above w are already zero
   function automatic logic [31:0] sext_field(logic [30:0] v, logic [4:0] w);
      logic sgn;
      if (w == 5'd0) begin
         return 32'd0;
      end
      sgn = v[5'(w - 5'd1)];
      return {1'b0, v} | (sgn ? (32'hFFFF_FFFF << w) : 32'h0);
   endfunction

   // 32-bit signed value into the pen width
   function automatic coord_type to_coord(logic [31:0] x);
      return COORD_WIDTH'(signed'(x));
   endfunction

   // pen value as shown on the result channel
   function automatic logic signed [31:0] show(coord_type c);
      return 32'(c);
   endfunction

endpackage

[hdl/gsrd_if.sv]
// byte stream channel
interface gsrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       glyph_start;
   logic       font_start;

   modport source (output valid, output data_byte, output glyph_start,
                   output font_start, input ready);
   modport sink (input valid, input data_byte, input glyph_start,
                 input font_start, output ready);
endinterface

// drawing command channel
interface gsrd_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         command;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] ctrl_x;
   logic signed [31:0] ctrl_y;
   logic               last;

   modport source (output valid, output command, output pos_x, output pos_y,
                   output ctrl_x, output ctrl_y, output last, input ready);
   modport sink (input valid, input command, input pos_x, input pos_y,
                 input ctrl_x, input ctrl_y, input last, output ready);
endinterface

[hdl/glyph_shape_record_decoder_top.sv]
// glyph shape record decoder
// req_chan carries the glyph shape stream one byte per item; glyph_start marks a
// header byte (fill index width in the high nibble, line index width in the low),
// font_start clears the pen before the byte is used.
// rsp_chan carries drawing commands with absolute coordinates; last marks the
// final command caused by one byte. a byte that causes no command gives no item.
// a header byte is taken without setting busy and keeps req ready high.
// a stream byte is shifted through the parser one bit per cycle, pausing while a
// field completes: after the accept it shifts its bits (at most 8), completes each
// field (zero-width fields included) and closes the byte, where a completion or the
// close can wait for the output; req ready comes back the cycle after the close.
// one command is held back to learn whether it is the last, and one sits in the
// output register; a held command reaches rsp the cycle after the next command
// completes or the byte closes, so the last command of a byte shows the cycle
// after the close. when the receiver stalls, parsing stops at the next command.
// reset (synchronous) clears the pen, the index widths and the record state, and
// the block waits for a glyph header; bytes before it are dropped.
`include "glyph_shape_record_decoder_top_defines.svh"

module glyph_shape_record_decoder_top (
   input logic       clock,
   input logic       reset,
   gsrd_req_if.sink  req_chan,
   gsrd_rsp_if.source rsp_chan
);
   import gsrd_pkg::*;

   logic            busy_ff, busy_in;
   logic [7:0]      byte_ff, byte_in;
   logic [3:0]      used_ff, used_in;
   logic [3:0]      phase_ff, phase_in;
   logic [4:0]      rem_ff, rem_in;
   logic [30:0]     acc_ff, acc_in;
   logic [3:0]      flags_ff, flags_in;
   logic [4:0]      dw_ff, dw_in;
   logic [2:0][16:0] pend_ff, pend_in;
   logic [3:0]      fiw_ff, fiw_in;
   logic [3:0]      liw_ff, liw_in;
   coord_type       pen_x_ff, pen_x_in;
   coord_type       pen_y_ff, pen_y_in;
   logic            hold_v_ff, hold_v_in;
   gsrd_result_type hold_ff, hold_in;
   logic            rsp_v_ff, rsp_v_in;
   gsrd_result_type rsp_ff, rsp_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            accept;
   logic            out_free;
   logic            parse_idle;
   logic            do_end, do_complete, do_shift;
   logic            end_go, complete_go;

   gsrd_step_type   sc_cur, sc_flags;
   logic [31:0]     field_ext;
   coord_type       d_coord, p0_coord, p1_coord, p2_coord;
   logic [1:0]      idx, kind;
   logic [2:0]      need;

   logic [3:0]      cmp_ph;
   logic [4:0]      cmp_w;
   logic            cmp_emit;
   gsrd_result_type cmp_res;
   logic [3:0]      cmp_flags;
   logic [4:0]      cmp_dw;
   logic [2:0][16:0] cmp_pend;
   coord_type       cmp_pen_x, cmp_pen_y, cmp_ctrl_x, cmp_ctrl_y;

   // handshake and step selection
   assign req_chan.ready = !busy_ff;
   assign accept         = req_chan.valid && !busy_ff;
   assign out_free       = !rsp_v_ff || rsp_chan.ready;
   assign parse_idle     = (phase_ff == PH_WAIT) || (phase_ff > PH_DELTA);
   assign do_end         = busy_ff && (parse_idle || (rem_ff != 5'd0 && used_ff == 4'd8));
   assign do_complete    = busy_ff && !parse_idle && rem_ff == 5'd0;
   assign do_shift       = busy_ff && !parse_idle && rem_ff != 5'd0 && used_ff != 4'd8;
   assign complete_go    = do_complete && (!cmp_emit || !hold_v_ff || out_free);
   assign end_go         = do_end && (!hold_v_ff || out_free);

   // field values seen by the completion logic
   assign sc_cur    = sc_next(phase_ff, flags_ff, fiw_ff, liw_ff);
   assign sc_flags  = sc_next(PH_FLAGS, acc_ff[3:0], fiw_ff, liw_ff);
   assign field_ext = sext_field(acc_ff, dw_ff);
   assign d_coord   = to_coord(field_ext);
   assign p0_coord  = to_coord({{15{pend_ff[0][16]}}, pend_ff[0]});
   assign p1_coord  = to_coord({{15{pend_ff[1][16]}}, pend_ff[1]});
   assign p2_coord  = to_coord({{15{pend_ff[2][16]}}, pend_ff[2]});
   assign idx       = flags_ff[1:0];
   assign kind      = flags_ff[3:2];
   assign need      = (kind == KIND_CURVE) ? 3'd4 : ((kind == KIND_LINE) ? 3'd2 : 3'd1);

   // field completion
   always_comb begin
      cmp_ph     = PH_WAIT;
      cmp_w      = 5'd0;
      cmp_emit   = 1'b0;
      cmp_res    = '0;
      cmp_flags  = flags_ff;
      cmp_dw     = dw_ff;
      cmp_pend   = pend_ff;
      cmp_pen_x  = pen_x_ff;
      cmp_pen_y  = pen_y_ff;
      cmp_ctrl_x = '0;
      cmp_ctrl_y = '0;
      unique case (phase_ff)
         PH_TYPE: begin
            if (acc_ff == '0) begin
               cmp_ph = PH_NEWSTYLE;
               cmp_w  = 5'd1;
            end else begin
               cmp_ph = PH_EDGEHEAD;
               cmp_w  = 5'd5;
            end
         end
         PH_NEWSTYLE: begin
            if (acc_ff != '0) begin
               cmp_ph = PH_TYPE;
               cmp_w  = 5'd1;
            end else begin
               cmp_ph = PH_FLAGS;
               cmp_w  = FLAG_BITS;
            end
         end
         PH_FLAGS: begin
            if (acc_ff == '0) begin
               cmp_emit            = 1'b1;
               cmp_res.command     = CMD_END;
            end else begin
               cmp_flags = acc_ff[3:0];
               cmp_ph    = sc_flags.phase;
               cmp_w     = sc_flags.width;
            end
         end
         PH_MBITS: begin
            cmp_dw = acc_ff[4:0];
            cmp_ph = PH_MX;
            cmp_w  = acc_ff[4:0];
         end
         PH_MX: begin
            cmp_pen_x = d_coord;
            cmp_ph    = PH_MY;
            cmp_w     = dw_ff;
         end
         PH_MY: begin
            cmp_pen_y       = d_coord;
            cmp_emit        = 1'b1;
            cmp_res.command = CMD_MOVE;
            cmp_res.pos_x   = show(pen_x_ff);
            cmp_res.pos_y   = show(d_coord);
            cmp_ph          = sc_cur.phase;
            cmp_w           = sc_cur.width;
         end
         PH_F0, PH_F1, PH_LS: begin
            cmp_emit = 1'b1;
            if (phase_ff == PH_F0) begin
               cmp_res.command = CMD_LEFT_FILL;
            end else if (phase_ff == PH_F1) begin
               cmp_res.command = CMD_RIGHT_FILL;
            end else begin
               cmp_res.command = CMD_LINE_OFF;
            end
            cmp_ph = sc_cur.phase;
            cmp_w  = sc_cur.width;
         end
         PH_EDGEHEAD: begin
            cmp_dw = 5'(acc_ff[3:0]) + 5'd2;
            if (acc_ff[4]) begin
               cmp_ph = PH_LINEGEN;
               cmp_w  = 5'd1;
            end else begin
               cmp_flags = {KIND_CURVE, 2'd0};
               cmp_ph    = PH_DELTA;
               cmp_w     = 5'(acc_ff[3:0]) + 5'd2;
            end
         end
         PH_LINEGEN: begin
            if (acc_ff != '0) begin
               cmp_flags = {KIND_LINE, 2'd0};
               cmp_ph    = PH_DELTA;
               cmp_w     = dw_ff;
            end else begin
               cmp_ph = PH_LINEVERT;
               cmp_w  = 5'd1;
            end
         end
         PH_LINEVERT: begin
            cmp_flags = (acc_ff != '0) ? {KIND_VERT, 2'd0} : {KIND_HORZ, 2'd0};
            cmp_ph    = PH_DELTA;
            cmp_w     = dw_ff;
         end
         PH_DELTA: begin
            if (({1'b0, idx} + 3'd1) < need && idx != 2'd3) begin
               // more deltas to come; keep this one until the edge closes
               cmp_pend[idx] = field_ext[16:0];
               cmp_flags     = {kind, idx + 2'd1};
               cmp_ph        = PH_DELTA;
               cmp_w         = dw_ff;
            end else begin
               cmp_emit = 1'b1;
               unique case (kind)
                  KIND_CURVE: begin
                     cmp_ctrl_x = pen_x_ff + p0_coord;
                     cmp_ctrl_y = pen_y_ff + p1_coord;
                     cmp_pen_x  = cmp_ctrl_x + p2_coord;
                     cmp_pen_y  = cmp_ctrl_y + d_coord;
                  end
                  KIND_LINE: begin
                     cmp_pen_x = pen_x_ff + p0_coord;
                     cmp_pen_y = pen_y_ff + d_coord;
                  end
                  KIND_VERT: begin
                     cmp_pen_y = pen_y_ff + d_coord;
                  end
                  default: begin
                     cmp_pen_x = pen_x_ff + d_coord;
                  end
               endcase
               cmp_res.pos_x = show(cmp_pen_x);
               cmp_res.pos_y = show(cmp_pen_y);
               if (kind == KIND_CURVE) begin
                  cmp_res.command = CMD_CURVE;
                  cmp_res.ctrl_x  = show(cmp_ctrl_x);
                  cmp_res.ctrl_y  = show(cmp_ctrl_y);
               end else begin
                  cmp_res.command = CMD_LINE;
               end
               cmp_ph = PH_TYPE;
               cmp_w  = 5'd1;
            end
         end
         default: begin
            cmp_ph = PH_WAIT;
            cmp_w  = 5'd0;
         end
      endcase
   end

   // next state
   always_comb begin
      busy_in     = busy_ff;
      byte_in     = byte_ff;
      used_in     = used_ff;
      phase_in    = phase_ff;
      rem_in      = rem_ff;
      acc_in      = acc_ff;
      flags_in    = flags_ff;
      dw_in       = dw_ff;
      pend_in     = pend_ff;
      fiw_in      = fiw_ff;
      liw_in      = liw_ff;
      pen_x_in    = pen_x_ff;
      pen_y_in    = pen_y_ff;
      hold_v_in   = hold_v_ff;
      hold_in     = hold_ff;
      rsp_v_in    = rsp_v_ff && !rsp_chan.ready;
      rsp_in      = rsp_ff;
      rsp_last_in = rsp_last_ff;

      // new byte
      if (accept) begin
         if (req_chan.font_start) begin
            pen_x_in = '0;
            pen_y_in = '0;
         end
         if (req_chan.glyph_start) begin
            fiw_in   = req_chan.data_byte[7:4];
            liw_in   = req_chan.data_byte[3:0];
            phase_in = PH_TYPE;
            rem_in   = 5'd1;
            acc_in   = '0;
         end else begin
            busy_in = 1'b1;
            byte_in = req_chan.data_byte;
            used_in = 4'd0;
         end
      end

      // one bit into the field shifter
      if (do_shift) begin
         acc_in  = {acc_ff[29:0], byte_ff[7]};
         byte_in = {byte_ff[6:0], 1'b0};
         used_in = used_ff + 4'd1;
         rem_in  = rem_ff - 5'd1;
      end

      // field done
      if (complete_go) begin
         phase_in  = cmp_ph;
         rem_in    = cmp_w;
         acc_in    = '0;
         flags_in  = cmp_flags;
         dw_in     = cmp_dw;
         pend_in   = cmp_pend;
         pen_x_in  = cmp_pen_x;
         pen_y_in  = cmp_pen_y;
         if (cmp_emit) begin
            if (hold_v_ff) begin
               rsp_v_in    = 1'b1;
               rsp_in      = hold_ff;
               rsp_last_in = 1'b0;
            end
            hold_v_in = 1'b1;
            hold_in   = cmp_res;
         end
      end

      // byte done, held command goes out as the last one
      if (end_go) begin
         busy_in = 1'b0;
         if (parse_idle) begin
            phase_in = PH_WAIT;
         end
         if (hold_v_ff) begin
            rsp_v_in    = 1'b1;
            rsp_in      = hold_ff;
            rsp_last_in = 1'b1;
         end
         hold_v_in = 1'b0;
      end
   end

   // control and record state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         used_ff   <= 4'd0;
         phase_ff  <= PH_WAIT;
         rem_ff    <= 5'd0;
         acc_ff    <= '0;
         flags_ff  <= 4'd0;
         dw_ff     <= 5'd0;
         pend_ff   <= '0;
         fiw_ff    <= 4'd0;
         liw_ff    <= 4'd0;
         pen_x_ff  <= '0;
         pen_y_ff  <= '0;
         hold_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         used_ff   <= used_in;
         phase_ff  <= phase_in;
         rem_ff    <= rem_in;
         acc_ff    <= acc_in;
         flags_ff  <= flags_in;
         dw_ff     <= dw_in;
         pend_ff   <= pend_in;
         fiw_ff    <= fiw_in;
         liw_ff    <= liw_in;
         pen_x_ff  <= pen_x_in;
         pen_y_ff  <= pen_y_in;
         hold_v_ff <= hold_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      hold_ff     <= hold_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   // result channel
   assign rsp_chan.valid   = rsp_v_ff;
   assign rsp_chan.command = rsp_ff.command;
   assign rsp_chan.pos_x   = rsp_ff.pos_x;
   assign rsp_chan.pos_y   = rsp_ff.pos_y;
   assign rsp_chan.ctrl_x  = rsp_ff.ctrl_x;
   assign rsp_chan.ctrl_y  = rsp_ff.ctrl_y;
   assign rsp_chan.last    = rsp_last_ff;

   // checks
   `GSRD_ASSERT_IMP(a_idle_no_hold, !busy_ff, !hold_v_ff, "held command while idle")
   `GSRD_ASSERT_NXT(a_close_last, end_go && hold_v_ff, rsp_v_ff && rsp_last_ff, "byte closed without last")
   `GSRD_ASSERT_NXT(a_byte_busy, accept && !req_chan.glyph_start, busy_ff, "stream byte not taken up")
   `GSRD_ASSERT_NXT(a_header_type, accept && req_chan.glyph_start, phase_ff == PH_TYPE && rem_ff == 5'd1, "header did not restart parse")

endmodule
